// ===== rtl/mfep_pkg.sv =====
// Shared types and constants of the MIDI file track event parser.
// No dependencies; the decoder, top level and checker take names from here by scope.
`default_nettype none

package mfep_pkg;

	typedef enum logic [2:0] {
		PH_DELTA,
		PH_STATUS,
		PH_DATA1,
		PH_DATA2,
		PH_SYSLEN,
		PH_METATYPE,
		PH_METALEN,
		PH_BODY
	} phase_t;

	localparam logic [3:0] KIND_NOTEOFF  = 4'd0;
	localparam logic [3:0] KIND_NOTEON   = 4'd1;
	localparam logic [3:0] KIND_SYSEX    = 4'd7;
	localparam logic [3:0] KIND_TRACKEND = 4'd8;
	localparam logic [3:0] KIND_TEMPO    = 4'd9;
	localparam logic [3:0] KIND_TIMESIG  = 4'd10;

	localparam logic [7:0] STATUS_SYSEX      = 8'hF0;
	localparam logic [7:0] STATUS_SYSEX_CONT = 8'hF7;
	localparam logic [7:0] STATUS_META       = 8'hFF;
	localparam logic [3:0] HI_PROGRAM        = 4'hC;
	localparam logic [3:0] HI_AFTERTOUCH     = 4'hD;

	localparam logic [7:0] META_TRACK_END = 8'h2F;
	localparam logic [7:0] META_TEMPO     = 8'h51;
	localparam logic [7:0] META_TIMESIG   = 8'h58;

	typedef struct packed {
		phase_t      phase;
		logic [27:0] delta_accum;
		logic [2:0]  vlq_count;
		logic [31:0] absolute_tick;
		logic [7:0]  running_status;
		logic [7:0]  current_status;
		logic [7:0]  held_data;
		logic [7:0]  meta_type;
		logic [27:0] body_remaining;
		logic [2:0]  body_index;
		logic [23:0] value_accum;
	} parse_state_t;

	typedef struct packed {
		logic [3:0]  event_kind;
		logic [3:0]  channel;
		logic        control_track;
		logic [7:0]  first_data;
		logic [7:0]  second_data;
		logic [31:0] event_tick;
		logic [23:0] tempo_micros;
		logic [7:0]  beats_per_bar;
		logic [6:0]  note_value;
		logic [27:0] sysex_length;
		logic        status_error;
	} event_t;

endpackage

`default_nettype wire

// ===== rtl/mfep_if.sv =====
// Valid/ready channels of the parser: track bytes in, decoded events out.
// Depends on nothing.
`default_nettype none

interface mfep_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       track_start;

	modport source (output valid, output data_byte, output track_start, input ready);
	modport sink (input valid, input data_byte, input track_start, output ready);
endinterface

interface mfep_event_if;
	logic        valid;
	logic        ready;
	logic [3:0]  event_kind;
	logic [3:0]  channel;
	logic        control_track;
	logic [7:0]  first_data;
	logic [7:0]  second_data;
	logic [31:0] event_tick;
	logic [23:0] tempo_micros;
	logic [7:0]  beats_per_bar;
	logic [6:0]  note_value;
	logic [27:0] sysex_length;
	logic        status_error;

	modport source (output valid, output event_kind, output channel, output control_track,
		output first_data, output second_data, output event_tick, output tempo_micros,
		output beats_per_bar, output note_value, output sysex_length, output status_error,
		input ready);
	modport sink (input valid, input event_kind, input channel, input control_track,
		input first_data, input second_data, input event_tick, input tempo_micros,
		input beats_per_bar, input note_value, input sysex_length, input status_error,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/mfep_decoder.sv =====
// Next-state and event decode for one track byte.
// Depends on mfep_pkg.
`default_nettype none

module mfep_decoder #(
	parameter int MAX_VLQ_BYTES = 4
) (
	input  wire mfep_pkg::parse_state_t state,
	input  wire logic [7:0]             data_byte,
	input  wire logic                   track_start,
	output mfep_pkg::parse_state_t      next_state,
	output logic                        emit,
	output mfep_pkg::event_t            result
);

	typedef struct packed {
		logic [27:0] acc;
		logic [2:0]  cnt;
		logic        done;
	} vlq_t;

	localparam logic [2:0] VLQ_MAX = 3'(MAX_VLQ_BYTES);

	function automatic vlq_t vlq_take(logic [27:0] acc, logic [2:0] cnt, logic [7:0] b);
		vlq_t r;
		r.acc  = {acc[20:0], b[6:0]};
		r.cnt  = (cnt < 3'd7) ? cnt + 3'd1 : cnt;
		r.done = !b[7] || (r.cnt >= VLQ_MAX);
		return r;
	endfunction

	mfep_pkg::parse_state_t st;
	vlq_t                   vlq_delta;
	vlq_t                   vlq_body;
	logic [3:0]             hi;
	logic [7:0]             cur;
	logic [2:0]             idx;
	logic [27:0]            rem_dec;
	logic [2:0]             den;

	always_comb begin
		st = state;
		if (track_start) begin
			st.absolute_tick  = '0;
			st.running_status = '0;
			st.phase          = mfep_pkg::PH_DELTA;
			st.delta_accum    = '0;
			st.vlq_count      = '0;
		end
	end

	assign vlq_delta = vlq_take(st.delta_accum, st.vlq_count, data_byte);
	assign vlq_body  = vlq_take(st.body_remaining, st.vlq_count, data_byte);
	assign rem_dec   = st.body_remaining - 28'd1;
	assign idx       = st.body_index;
	assign den       = (data_byte < 8'd6) ? data_byte[2:0] : 3'd6;

	always_comb begin
		cur = st.current_status;
		if (st.phase == mfep_pkg::PH_STATUS && !data_byte[7])
			cur = st.running_status;
	end
	assign hi = cur[7:4];

	always_comb begin
		next_state        = st;
		emit              = 1'b0;
		result            = '0;
		result.event_tick = st.absolute_tick;
		unique case (st.phase)
			mfep_pkg::PH_DELTA: begin
				next_state.delta_accum = vlq_delta.acc;
				next_state.vlq_count   = vlq_delta.cnt;
				if (vlq_delta.done) begin
					next_state.absolute_tick = st.absolute_tick + {4'd0, vlq_delta.acc};
					next_state.phase         = mfep_pkg::PH_STATUS;
					next_state.vlq_count     = '0;
				end
			end
			mfep_pkg::PH_STATUS, mfep_pkg::PH_DATA1: begin
				if (st.phase == mfep_pkg::PH_STATUS && data_byte[7]) begin
					next_state.current_status = data_byte;
					if (data_byte < mfep_pkg::STATUS_SYSEX) begin
						next_state.running_status = data_byte;
						next_state.phase          = mfep_pkg::PH_DATA1;
					end else if (data_byte == mfep_pkg::STATUS_SYSEX ||
							data_byte == mfep_pkg::STATUS_SYSEX_CONT) begin
						next_state.body_remaining = '0;
						next_state.vlq_count      = '0;
						next_state.phase          = mfep_pkg::PH_SYSLEN;
					end else if (data_byte == mfep_pkg::STATUS_META) begin
						next_state.phase = mfep_pkg::PH_METATYPE;
					end else begin
						next_state.phase       = mfep_pkg::PH_DELTA;
						next_state.delta_accum = '0;
						next_state.vlq_count   = '0;
					end
				end else if (st.phase == mfep_pkg::PH_STATUS && st.running_status == '0) begin
					emit                   = 1'b1;
					result.status_error    = 1'b1;
					next_state.phase       = mfep_pkg::PH_DELTA;
					next_state.delta_accum = '0;
					next_state.vlq_count   = '0;
				end else begin
					next_state.current_status = cur;
					next_state.held_data      = data_byte;
					if (hi == mfep_pkg::HI_PROGRAM || hi == mfep_pkg::HI_AFTERTOUCH) begin
						emit                   = 1'b1;
						result.event_kind      = hi - 4'd8;
						result.channel         = cur[3:0];
						result.first_data      = data_byte;
						next_state.phase       = mfep_pkg::PH_DELTA;
						next_state.delta_accum = '0;
						next_state.vlq_count   = '0;
					end else begin
						next_state.phase = mfep_pkg::PH_DATA2;
					end
				end
			end
			mfep_pkg::PH_DATA2: begin
				emit              = 1'b1;
				result.event_kind = hi - 4'd8;
				if (result.event_kind == mfep_pkg::KIND_NOTEON && data_byte == 8'd0)
					result.event_kind = mfep_pkg::KIND_NOTEOFF;
				result.channel         = cur[3:0];
				result.first_data      = st.held_data;
				result.second_data     = data_byte;
				next_state.phase       = mfep_pkg::PH_DELTA;
				next_state.delta_accum = '0;
				next_state.vlq_count   = '0;
			end
			mfep_pkg::PH_SYSLEN: begin
				next_state.body_remaining = vlq_body.acc;
				next_state.vlq_count      = vlq_body.cnt;
				if (vlq_body.done) begin
					emit                  = 1'b1;
					result.event_kind     = mfep_pkg::KIND_SYSEX;
					result.control_track  = 1'b1;
					result.sysex_length   = vlq_body.acc;
					next_state.meta_type  = '0;
					next_state.body_index = '0;
					if (vlq_body.acc == '0) begin
						next_state.phase       = mfep_pkg::PH_DELTA;
						next_state.delta_accum = '0;
						next_state.vlq_count   = '0;
					end else begin
						next_state.phase = mfep_pkg::PH_BODY;
					end
				end
			end
			mfep_pkg::PH_METATYPE: begin
				next_state.meta_type      = data_byte;
				next_state.body_remaining = '0;
				next_state.vlq_count      = '0;
				next_state.phase          = mfep_pkg::PH_METALEN;
			end
			mfep_pkg::PH_METALEN: begin
				next_state.body_remaining = vlq_body.acc;
				next_state.vlq_count      = vlq_body.cnt;
				if (vlq_body.done) begin
					next_state.body_index  = '0;
					next_state.value_accum = '0;
					if (vlq_body.acc == '0) begin
						next_state.phase       = mfep_pkg::PH_DELTA;
						next_state.delta_accum = '0;
						next_state.vlq_count   = '0;
					end else begin
						next_state.phase = mfep_pkg::PH_BODY;
					end
					if (st.meta_type == mfep_pkg::META_TRACK_END) begin
						emit                 = 1'b1;
						result.event_kind    = mfep_pkg::KIND_TRACKEND;
						result.control_track = 1'b1;
					end
				end
			end
			mfep_pkg::PH_BODY: begin
				if (idx < 3'd7)
					next_state.body_index = idx + 3'd1;
				next_state.body_remaining = rem_dec;
				if (rem_dec == '0) begin
					next_state.phase       = mfep_pkg::PH_DELTA;
					next_state.delta_accum = '0;
					next_state.vlq_count   = '0;
				end
				if (st.meta_type == mfep_pkg::META_TEMPO && idx < 3'd3) begin
					next_state.value_accum = {st.value_accum[15:0], data_byte};
					if (idx == 3'd2) begin
						emit                 = 1'b1;
						result.event_kind    = mfep_pkg::KIND_TEMPO;
						result.control_track = 1'b1;
						result.tempo_micros  = {st.value_accum[15:0], data_byte};
					end
				end else if (st.meta_type == mfep_pkg::META_TIMESIG) begin
					if (idx == 3'd0) begin
						next_state.held_data = data_byte;
					end else if (idx == 3'd1) begin
						emit                 = 1'b1;
						result.event_kind    = mfep_pkg::KIND_TIMESIG;
						result.control_track = 1'b1;
						result.beats_per_bar = st.held_data;
						result.note_value    = 7'd1 << den;
					end
				end
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/midi_file_event_parser_top.sv =====
// Top level of the MIDI file track event parser: input register, decode, result register.
// Depends on mfep_pkg, mfep_if and mfep_decoder.
//
// The parser takes one track byte per clock cycle and keeps that rate as long as each
// event is taken when it is offered: a byte is registered, decoded in a single stage
// against the parse state, and any event it completes lands in the result register when
// the byte leaves the input register. The byte input register and the result register
// bound this path; a stalled event channel holds at most one byte in the input register
// before the track channel stops taking words.
`default_nettype none

module midi_file_event_parser_top #(
	parameter int MAX_VLQ_BYTES = 4
) (
	input wire logic      clk,
	input wire logic      arst_n,
	mfep_byte_if.sink     track,
	mfep_event_if.source  events
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   start_s1;
	logic                   out_valid_q;
	mfep_pkg::event_t       result_q;
	mfep_pkg::parse_state_t state_q;
	mfep_pkg::parse_state_t next_state;
	mfep_pkg::event_t       result;
	logic                   emit;
	logic                   advance;
	logic                   fire;

	assign advance     = !out_valid_q || events.ready;
	assign fire        = valid_s1 && advance;
	assign track.ready = !valid_s1 || advance;

	mfep_decoder #(
		.MAX_VLQ_BYTES(MAX_VLQ_BYTES)
	) u_decoder (
		.state      (state_q),
		.data_byte  (byte_s1),
		.track_start(start_s1),
		.next_state (next_state),
		.emit       (emit),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '{phase: mfep_pkg::PH_DELTA, default: '0};
		end else begin
			valid_s1 <= (track.valid && track.ready) || (valid_s1 && !advance);
			if (fire) begin
				state_q     <= next_state;
				out_valid_q <= emit;
			end else if (events.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (track.valid && track.ready) begin
			byte_s1  <= track.data_byte;
			start_s1 <= track.track_start;
		end
		if (fire && emit)
			result_q <= result;
	end

	assign events.valid         = out_valid_q;
	assign events.event_kind    = result_q.event_kind;
	assign events.channel       = result_q.channel;
	assign events.control_track = result_q.control_track;
	assign events.first_data    = result_q.first_data;
	assign events.second_data   = result_q.second_data;
	assign events.event_tick    = result_q.event_tick;
	assign events.tempo_micros  = result_q.tempo_micros;
	assign events.beats_per_bar = result_q.beats_per_bar;
	assign events.note_value    = result_q.note_value;
	assign events.sysex_length  = result_q.sysex_length;
	assign events.status_error  = result_q.status_error;

endmodule

`default_nettype wire

// ===== rtl/mfep_checker.sv =====
// Port-level assertions for the MIDI file track event parser, bound to its top level.
// Depends on mfep_pkg and midi_file_event_parser_top.
`default_nettype none

module mfep_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        valid,
	input wire logic        ready,
	input wire logic [3:0]  event_kind,
	input wire logic [3:0]  channel,
	input wire logic        control_track,
	input wire logic [7:0]  first_data,
	input wire logic [31:0] event_tick,
	input wire logic [6:0]  note_value,
	input wire logic        status_error
);

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid)
		else $error("event word withdrawn while stalled");

	a_word_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> $stable(event_kind) && $stable(event_tick))
		else $error("stalled event word changed");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid && status_error |-> event_kind == mfep_pkg::KIND_NOTEOFF && channel == 4'd0
			&& !control_track && first_data == 8'd0)
		else $error("error word carries event fields");

	a_control_kind: assert property (@(posedge clk) disable iff (!arst_n)
		valid && control_track |-> (event_kind == mfep_pkg::KIND_SYSEX
			|| event_kind == mfep_pkg::KIND_TRACKEND || event_kind == mfep_pkg::KIND_TEMPO
			|| event_kind == mfep_pkg::KIND_TIMESIG) && channel == 4'd0)
		else $error("control word with channel kind");

	a_note_value: assert property (@(posedge clk) disable iff (!arst_n)
		valid && event_kind != mfep_pkg::KIND_TIMESIG |-> note_value == 7'd0)
		else $error("note value outside time signature");

endmodule

bind midi_file_event_parser_top mfep_checker u_mfep_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (events.valid),
	.ready        (events.ready),
	.event_kind   (events.event_kind),
	.channel      (events.channel),
	.control_track(events.control_track),
	.first_data   (events.first_data),
	.event_tick   (events.event_tick),
	.note_value   (events.note_value),
	.status_error (events.status_error)
);

`default_nettype wire
